// ----- rtl/ptds_pkg.sv -----
`timescale 1ns / 1ps

package ptds_pkg;

	localparam int SLOT_IDX_W = 5;

	typedef enum logic [2:0] {
		ACT_TICK   = 3'd0,
		ACT_ADD    = 3'd1,
		ACT_ENABLE = 3'd2,
		ACT_CANCEL = 3'd3,
		ACT_SCAN   = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		KIND_ACK  = 2'd0,
		KIND_FIRE = 2'd1,
		KIND_END  = 2'd2
	} kind_t;

	typedef struct packed {
		logic [31:0] tag;
		logic [31:0] arg;
		logic [31:0] period;
		logic [31:0] deadline;
	} slot_entry_t;

	typedef struct packed {
		logic                  en;
		logic [SLOT_IDX_W-1:0] addr;
		slot_entry_t           data;
	} slot_wr_t;

	typedef struct packed {
		kind_t                 kind;
		logic                  ok;
		logic [SLOT_IDX_W-1:0] slot_index;
		logic [31:0]           fired_tag;
		logic [31:0]           fired_arg;
		logic [31:0]           time_now;
		logic                  any_fired;
		logic                  last;
	} result_t;

endpackage

// ----- rtl/ptds_req_if.sv -----
`timescale 1ns / 1ps

interface ptds_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  action;
	logic [31:0] handler_tag;
	logic [31:0] handler_arg;
	logic [31:0] period_ticks;
	logic [31:0] delay_ticks;
	logic [5:0]  slot;
	logic        enable_flag;

	modport source (
		output valid, action, handler_tag, handler_arg, period_ticks, delay_ticks, slot,
			enable_flag,
		input  ready
	);

	modport sink (
		input  valid, action, handler_tag, handler_arg, period_ticks, delay_ticks, slot,
			enable_flag,
		output ready
	);
endinterface

// ----- rtl/ptds_rsp_if.sv -----
`timescale 1ns / 1ps

interface ptds_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic        ok;
	logic [4:0]  slot_index;
	logic [31:0] fired_tag;
	logic [31:0] fired_arg;
	logic [31:0] time_now;
	logic        any_fired;
	logic        last;

	modport source (
		output valid, kind, ok, slot_index, fired_tag, fired_arg, time_now, any_fired, last,
		input  ready
	);

	modport sink (
		input  valid, kind, ok, slot_index, fired_tag, fired_arg, time_now, any_fired, last,
		output ready
	);
endinterface

// ----- rtl/ptds_slot_mem.sv -----
`timescale 1ns / 1ps

module ptds_slot_mem import ptds_pkg::*; #(
	parameter int SLOT_COUNT = 8
) (
	input  logic                  clk,
	input  slot_wr_t              wr,
	input  logic                  rd_en,
	input  logic [SLOT_IDX_W-1:0] rd_addr,
	output slot_entry_t           rd_data
);
	localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	slot_entry_t mem [SLOT_COUNT];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr[IW-1:0]] <= wr.data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr[IW-1:0]];
		end
	end
endmodule

// ----- rtl/ptds_out_stage.sv -----
`timescale 1ns / 1ps

module ptds_out_stage import ptds_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t res,
	output logic    free,
	ptds_rsp_if.source rsp
);
	logic    valid_q;
	result_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (rsp.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign free           = !valid_q || rsp.ready;
	assign rsp.valid      = valid_q;
	assign rsp.kind       = res_q.kind;
	assign rsp.ok         = res_q.ok;
	assign rsp.slot_index = res_q.slot_index;
	assign rsp.fired_tag  = res_q.fired_tag;
	assign rsp.fired_arg  = res_q.fired_arg;
	assign rsp.time_now   = res_q.time_now;
	assign rsp.any_fired  = res_q.any_fired;
	assign rsp.last       = res_q.last;
endmodule

// ----- rtl/periodic_task_deadline_scheduler.sv -----
`timescale 1ns / 1ps

// Periodic task deadline scheduler: the acknowledge of a tick, add, enable or cancel, or of an
// unsupported action code with ok cleared, is loaded into the output register at the accepting
// edge; a new transaction is taken whenever the block is idle and the output register is empty
// or being drained. A scan walks the SLOT_COUNT slots through the single read port of the slot
// table, one slot per cycle while no due slot is held off by the output side, with the read of
// the next slot overlapping the due check and write-back of the current one.

module periodic_task_deadline_scheduler import ptds_pkg::*; #(
	parameter int SLOT_COUNT = 8
) (
	input  logic clk,
	input  logic arst_n,
	ptds_req_if.sink   req,
	ptds_rsp_if.source rsp
);
	localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_END  = 3'b100
	} state_t;

	state_t                state_q;
	logic [31:0]           tick_q;
	logic [SLOT_COUNT-1:0] used_q;
	logic [SLOT_COUNT-1:0] en_q;
	logic [IW-1:0]         rd_ptr_q;
	logic                  rd_more_q;
	logic                  any_q;
	logic                  ev_valid_s1;
	logic [IW-1:0]         ev_idx_s1;

	logic        out_free;
	logic        out_load;
	result_t     res;
	slot_wr_t    wr;
	logic        rd_en;
	slot_entry_t rd_data;

	logic          accept;
	logic          free_hit;
	logic [IW-1:0] free_idx;
	logic          slot_ok;
	logic [IW-1:0] slot_sel;
	logic          add_ok;
	logic [31:0]   diff;
	logic          ev_due;
	logic          stall;
	logic          fire_go;

	ptds_slot_mem #(.SLOT_COUNT(SLOT_COUNT)) u_mem (
		.clk     (clk),
		.wr      (wr),
		.rd_en   (rd_en),
		.rd_addr (SLOT_IDX_W'(rd_ptr_q)),
		.rd_data (rd_data)
	);

	ptds_out_stage u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (out_load),
		.res    (res),
		.free   (out_free),
		.rsp    (rsp)
	);

	assign req.ready = (state_q == ST_IDLE) && out_free;
	assign accept    = req.valid && req.ready;

	always_comb begin
		free_hit = 1'b0;
		free_idx = '0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_hit = 1'b1;
				free_idx = IW'(i);
			end
		end
	end

	assign slot_ok  = req.slot < 6'(SLOT_COUNT);
	assign slot_sel = req.slot[IW-1:0];
	assign add_ok   = (req.handler_tag != 32'd0) && free_hit;

	assign diff    = tick_q - rd_data.deadline;
	assign ev_due  = ev_valid_s1 && used_q[ev_idx_s1] && en_q[ev_idx_s1] && !diff[31];
	assign stall   = ev_due && !out_free;
	assign fire_go = (state_q == ST_SCAN) && ev_due && out_free;

	always_comb begin
		res          = '0;
		res.kind     = KIND_ACK;
		res.last     = 1'b1;
		res.time_now = tick_q;
		out_load     = 1'b0;
		wr           = '0;
		rd_en        = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (action_t'(req.action))
						ACT_TICK: begin
							out_load     = 1'b1;
							res.ok       = 1'b1;
							res.time_now = tick_q + 32'd1;
						end
						ACT_ADD: begin
							out_load = 1'b1;
							res.ok   = add_ok;
							if (add_ok) begin
								res.slot_index   = SLOT_IDX_W'(free_idx);
								wr.en            = 1'b1;
								wr.addr          = SLOT_IDX_W'(free_idx);
								wr.data.tag      = req.handler_tag;
								wr.data.arg      = req.handler_arg;
								wr.data.period   = req.period_ticks;
								wr.data.deadline = tick_q + req.delay_ticks;
							end
						end
						ACT_ENABLE, ACT_CANCEL: begin
							out_load = 1'b1;
							res.ok   = slot_ok;
						end
						ACT_SCAN: begin
						end
						default: begin
							out_load = 1'b1;
							res.ok   = 1'b0;
						end
					endcase
				end
			end
			ST_SCAN: begin
				rd_en = !stall && rd_more_q;
				if (fire_go) begin
					out_load       = 1'b1;
					res.kind       = KIND_FIRE;
					res.ok         = 1'b1;
					res.slot_index = SLOT_IDX_W'(ev_idx_s1);
					res.fired_tag  = rd_data.tag;
					res.fired_arg  = rd_data.arg;
					res.last       = 1'b0;
					if (rd_data.period != 32'd0) begin
						wr.en            = 1'b1;
						wr.addr          = SLOT_IDX_W'(ev_idx_s1);
						wr.data          = rd_data;
						wr.data.deadline = rd_data.deadline + rd_data.period;
					end
				end
			end
			ST_END: begin
				out_load      = out_free;
				res.kind      = KIND_END;
				res.ok        = 1'b1;
				res.any_fired = any_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tick_q      <= '0;
			used_q      <= '0;
			en_q        <= '0;
			rd_ptr_q    <= '0;
			rd_more_q   <= 1'b0;
			any_q       <= 1'b0;
			ev_valid_s1 <= 1'b0;
			ev_idx_s1   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (action_t'(req.action))
							ACT_TICK: begin
								tick_q <= tick_q + 32'd1;
							end
							ACT_ADD: begin
								if (add_ok) begin
									used_q[free_idx] <= 1'b1;
									en_q[free_idx]   <= 1'b1;
								end
							end
							ACT_ENABLE: begin
								if (slot_ok && used_q[slot_sel]) begin
									en_q[slot_sel] <= req.enable_flag;
								end
							end
							ACT_CANCEL: begin
								if (slot_ok) begin
									used_q[slot_sel] <= 1'b0;
									en_q[slot_sel]   <= 1'b0;
								end
							end
							ACT_SCAN: begin
								state_q     <= ST_SCAN;
								rd_ptr_q    <= '0;
								rd_more_q   <= 1'b1;
								any_q       <= 1'b0;
								ev_valid_s1 <= 1'b0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (fire_go) begin
						any_q <= 1'b1;
						if (rd_data.period == 32'd0) begin
							used_q[ev_idx_s1] <= 1'b0;
							en_q[ev_idx_s1]   <= 1'b0;
						end
					end
					if (!stall) begin
						ev_valid_s1 <= rd_more_q;
						ev_idx_s1   <= rd_ptr_q;
						if (rd_more_q) begin
							if (rd_ptr_q == IW'(SLOT_COUNT - 1)) begin
								rd_more_q <= 1'b0;
							end else begin
								rd_ptr_q <= rd_ptr_q + IW'(1);
							end
						end else begin
							state_q <= ST_END;
						end
					end
				end
				ST_END: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_free)
		else $error("result loaded into a full output register");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && stall) |=> (ev_valid_s1 && $stable(ev_idx_s1)
			&& $stable(rd_ptr_q)))
		else $error("scan advanced while a fire transaction was held off");

	a_oneshot_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_go && rd_data.period == 32'd0) |=> !used_q[$past(ev_idx_s1)])
		else $error("one-shot slot still in use after firing");

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> (!ev_valid_s1 && !rd_more_q))
		else $error("new transaction taken while a scan is in flight");
endmodule

// ----- tb/tb_periodic_task_deadline_scheduler.sv -----
`timescale 1ns / 1ps

module tb_periodic_task_deadline_scheduler;
	import ptds_pkg::*;

	localparam int CLK_PERIOD = 12;
	localparam int SLOT_COUNT = 8;
	localparam int RANDOM_ACTIONS = 250;
	localparam int TAIL_ACTIONS = 30;
	localparam int LONG_HOLD = 300;
	localparam int SETTLE_CYCLES = 4 * (SLOT_COUNT + 3);
	localparam int RUN_LIMIT_CYCLES = 600000;
	localparam logic [2:0] ACT_UNUSED_LO = 3'd5;
	localparam logic [2:0] ACT_UNUSED_HI = 3'd7;

	typedef struct {
		logic [2:0]  action;
		logic [31:0] handler_tag;
		logic [31:0] handler_arg;
		logic [31:0] period_ticks;
		logic [31:0] delay_ticks;
		logic [5:0]  slot;
		logic        enable_flag;
		bit          drain_first;
		bit          hold_rsp;
	} sched_action_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ptds_req_if req_ch();
	ptds_rsp_if rsp_ch();

	periodic_task_deadline_scheduler #(
		.SLOT_COUNT(SLOT_COUNT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// scheduler state as the block should hold it
	logic [31:0] tick_now = '0;
	logic        sl_used     [SLOT_COUNT] = '{default: 1'b0};
	logic        sl_enabled  [SLOT_COUNT] = '{default: 1'b0};
	logic [31:0] sl_period   [SLOT_COUNT] = '{default: '0};
	logic [31:0] sl_deadline [SLOT_COUNT] = '{default: '0};
	logic [31:0] sl_tag      [SLOT_COUNT] = '{default: '0};
	logic [31:0] sl_arg      [SLOT_COUNT] = '{default: '0};

	sched_action_t action_queue[$];
	result_t       sched_events[$];
	int            events_predicted = 0;
	int            events_received = 0;
	int            error_count = 0;

	sched_action_t cur_action;
	int            send_gap = 0;
	int            send_rate = 0;
	int            send_cycle = 0;
	logic          hold_req = 1'b0;
	logic          tail_phase = 1'b0;

	int            sink_gap = 0;
	int            sink_rate = 0;
	int            sink_cycle = 0;
	int            hold_left = 0;
	logic          hold_seen = 1'b0;

	function automatic void free_slot(input int s);
		sl_used[s] = 1'b0;
		sl_enabled[s] = 1'b0;
		sl_period[s] = '0;
		sl_deadline[s] = '0;
		sl_tag[s] = '0;
		sl_arg[s] = '0;
	endfunction

	function automatic void apply_action(input sched_action_t a);
		result_t     r;
		logic [31:0] lag;
		bit          any;
		bit          placed;
		r = '0;
		r.kind = KIND_ACK;
		r.last = 1'b1;
		any = 1'b0;
		placed = 1'b0;
		case (a.action)
			ACT_TICK: begin
				tick_now = tick_now + 32'd1;
				r.ok = 1'b1;
			end
			ACT_ADD: begin
				if (a.handler_tag != '0) begin
					for (int s = 0; s < SLOT_COUNT; s++) begin
						if (!placed && !sl_used[s]) begin
							sl_used[s] = 1'b1;
							sl_enabled[s] = 1'b1;
							sl_tag[s] = a.handler_tag;
							sl_arg[s] = a.handler_arg;
							sl_period[s] = a.period_ticks;
							sl_deadline[s] = tick_now + a.delay_ticks;
							r.ok = 1'b1;
							r.slot_index = SLOT_IDX_W'(s);
							placed = 1'b1;
						end
					end
				end
			end
			ACT_ENABLE: begin
				if (a.slot < SLOT_COUNT) begin
					if (sl_used[a.slot])
						sl_enabled[a.slot] = a.enable_flag;
					r.ok = 1'b1;
				end
			end
			ACT_CANCEL: begin
				if (a.slot < SLOT_COUNT) begin
					free_slot(a.slot);
					r.ok = 1'b1;
				end
			end
			ACT_SCAN: begin
				for (int s = 0; s < SLOT_COUNT; s++) begin
					if (sl_used[s] && sl_enabled[s]) begin
						lag = tick_now - sl_deadline[s];
						if (!lag[31]) begin
							r = '0;
							r.kind = KIND_FIRE;
							r.ok = 1'b1;
							r.slot_index = SLOT_IDX_W'(s);
							r.fired_tag = sl_tag[s];
							r.fired_arg = sl_arg[s];
							r.time_now = tick_now;
							sched_events.push_back(r);
							events_predicted++;
							any = 1'b1;
							if (sl_period[s] == '0)
								free_slot(s);
							else
								sl_deadline[s] = sl_deadline[s] + sl_period[s];
						end
					end
				end
				r = '0;
				r.kind = KIND_END;
				r.ok = 1'b1;
				r.any_fired = any;
				r.last = 1'b1;
			end
			default: begin
				r.ok = 1'b0;
			end
		endcase
		r.time_now = tick_now;
		sched_events.push_back(r);
		events_predicted++;
	endfunction

	function automatic sched_action_t mk(input logic [2:0] act, input logic [31:0] tag,
			input logic [31:0] arg, input logic [31:0] per, input logic [31:0] dly,
			input logic [5:0] sl, input logic en);
		sched_action_t a;
		a.action = act;
		a.handler_tag = tag;
		a.handler_arg = arg;
		a.period_ticks = per;
		a.delay_ticks = dly;
		a.slot = sl;
		a.enable_flag = en;
		a.drain_first = 1'b0;
		a.hold_rsp = 1'b0;
		return a;
	endfunction

	function automatic sched_action_t random_action();
		sched_action_t a;
		int unsigned   pick;
		a = mk(ACT_TICK, '0, $urandom, '0, '0, '0, 1'b0);
		pick = $urandom_range(0, 99);
		if (pick < 30)
			a.action = ACT_TICK;
		else if (pick < 52)
			a.action = ACT_ADD;
		else if (pick < 77)
			a.action = ACT_SCAN;
		else if (pick < 86)
			a.action = ACT_ENABLE;
		else if (pick < 97)
			a.action = ACT_CANCEL;
		else
			a.action = 3'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));

		pick = $urandom_range(0, 15);
		if (pick == 0)
			a.handler_tag = '0;
		else if (pick < 5)
			a.handler_tag = $urandom;
		else
			a.handler_tag = $urandom_range(1, 255);

		pick = $urandom_range(0, 99);
		if (pick < 40)
			a.period_ticks = '0;
		else if (pick < 85)
			a.period_ticks = $urandom_range(1, 8);
		else
			a.period_ticks = $urandom;

		pick = $urandom_range(0, 99);
		if (pick < 70)
			a.delay_ticks = $urandom_range(0, 10);
		else if (pick < 80)
			a.delay_ticks = 32'h8000_0000 + $urandom_range(0, 2) - 32'd1;
		else if (pick < 85)
			a.delay_ticks = 32'hFFFF_FFFF;
		else
			a.delay_ticks = $urandom;

		if ($urandom_range(0, 99) < 85)
			a.slot = 6'($urandom_range(0, SLOT_COUNT - 1));
		else
			a.slot = 6'($urandom_range(0, 63));
		a.enable_flag = ($urandom_range(0, 9) < 7);
		return a;
	endfunction

	function automatic void check_field(input string fname, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0h, actual %0h", fname, want, got);
			error_count++;
		end
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			send_gap = 0;
		end else begin
			if (req_ch.valid && req_ch.ready)
				apply_action(cur_action);
			send_cycle++;
			if (send_cycle % 64 == 0)
				send_rate = 4 * $urandom_range(0, 3);
			tail_phase <= (action_queue.size() < TAIL_ACTIONS);
			if (!req_ch.valid || req_ch.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					req_ch.valid <= 1'b0;
				end else if (action_queue.size() > 0 && !(action_queue[0].drain_first &&
						events_predicted != events_received)) begin
					cur_action = action_queue.pop_front();
					req_ch.valid <= 1'b1;
					req_ch.action <= cur_action.action;
					req_ch.handler_tag <= cur_action.handler_tag;
					req_ch.handler_arg <= cur_action.handler_arg;
					req_ch.period_ticks <= cur_action.period_ticks;
					req_ch.delay_ticks <= cur_action.delay_ticks;
					req_ch.slot <= cur_action.slot;
					req_ch.enable_flag <= cur_action.enable_flag;
					if (cur_action.hold_rsp)
						hold_req <= ~hold_req;
					if (action_queue.size() >= TAIL_ACTIONS && send_rate != 0 &&
							$urandom_range(0, send_rate - 1) == 0)
						send_gap = $urandom_range(1, 18);
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result side ready
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			sink_gap = 0;
			hold_left = 0;
		end else begin
			sink_cycle++;
			if (sink_cycle % 64 == 0)
				sink_rate = 4 * $urandom_range(0, 3);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (sink_gap > 0) begin
				sink_gap--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
				if (!tail_phase && sink_rate != 0 && $urandom_range(0, sink_rate - 1) == 0)
					sink_gap = $urandom_range(1, 18);
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		result_t ev;
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			events_received <= events_received + 1;
			if (sched_events.size() == 0) begin
				$error("unexpected transaction: kind %0d slot %0d", rsp_ch.kind,
					rsp_ch.slot_index);
				error_count++;
			end else begin
				ev = sched_events.pop_front();
				check_field("kind", 32'(ev.kind), 32'(rsp_ch.kind));
				check_field("ok", 32'(ev.ok), 32'(rsp_ch.ok));
				check_field("slot_index", 32'(ev.slot_index), 32'(rsp_ch.slot_index));
				check_field("fired_tag", ev.fired_tag, rsp_ch.fired_tag);
				check_field("fired_arg", ev.fired_arg, rsp_ch.fired_arg);
				check_field("time_now", ev.time_now, rsp_ch.time_now);
				check_field("any_fired", 32'(ev.any_fired), 32'(rsp_ch.any_fired));
				check_field("last", 32'(ev.last), 32'(rsp_ch.last));
			end
		end
	end

	initial begin
		sched_action_t a;
		req_ch.valid = 1'b0;
		req_ch.action = ACT_TICK;
		req_ch.handler_tag = '0;
		req_ch.handler_arg = '0;
		req_ch.period_ticks = '0;
		req_ch.delay_ticks = '0;
		req_ch.slot = '0;
		req_ch.enable_flag = 1'b0;
		rsp_ch.ready = 1'b0;

		action_queue.push_back(mk(ACT_SCAN, '0, '0, '0, '0, '0, 1'b0));
		action_queue.push_back(mk(ACT_ADD, '0, 32'h1234, 32'd1, '0, '0, 1'b1));
		action_queue.push_back(mk(ACT_ADD, '1, '1, '0, '0, '0, 1'b0));
		action_queue.push_back(mk(ACT_ADD, 32'd1, '0, '1, '1, '1, 1'b1));
		action_queue.push_back(mk(ACT_ADD, 32'd2, 32'h5555_5555, 32'd1, 32'h8000_0000,
			'0, 1'b0));
		action_queue.push_back(mk(ACT_ADD, 32'd3, 32'hAAAA_AAAA, 32'd3, 32'h8000_0001,
			'0, 1'b0));
		for (int i = 0; i < 4; i++)
			action_queue.push_back(mk(ACT_ADD, 32'd10 + i, 32'd100 + i, 32'd2, i, '0, 1'b0));
		action_queue.push_back(mk(ACT_ADD, 32'd99, '0, '0, '0, '0, 1'b0));
		action_queue.push_back(mk(ACT_ENABLE, '0, '0, '0, '0, 6'd63, 1'b1));
		action_queue.push_back(mk(ACT_ENABLE, '0, '0, '0, '0, 6'(SLOT_COUNT), 1'b1));
		action_queue.push_back(mk(ACT_ENABLE, '0, '0, '0, '0, 6'd2, 1'b0));
		action_queue.push_back(mk(ACT_CANCEL, '0, '0, '0, '0, 6'd40, 1'b0));
		action_queue.push_back(mk(ACT_SCAN, '0, '0, '0, '0, '0, 1'b0));
		action_queue.push_back(mk(ACT_TICK, '1, '1, '1, '1, '1, 1'b1));
		action_queue.push_back(mk(ACT_SCAN, '0, '0, '0, '0, '0, 1'b0));
		action_queue.push_back(mk(ACT_CANCEL, '0, '0, '0, '0, 6'd0, 1'b0));
		action_queue.push_back(mk(ACT_ENABLE, '0, '0, '0, '0, 6'd0, 1'b1));
		action_queue.push_back(mk(ACT_ENABLE, '0, '0, '0, '0, 6'd2, 1'b1));
		action_queue.push_back(mk(ACT_UNUSED_LO, 32'd7, '0, '0, '0, 6'd1, 1'b1));
		action_queue.push_back(mk(ACT_UNUSED_HI, '0, '0, '0, '0, 6'd1, 1'b0));
		action_queue.push_back(mk(ACT_TICK, '0, '0, '0, '0, '0, 1'b0));
		action_queue.push_back(mk(ACT_SCAN, '0, '0, '0, '0, '0, 1'b0));
		action_queue.push_back(mk(ACT_CANCEL, '0, '0, '0, '0, 6'(SLOT_COUNT - 1), 1'b0));

		for (int i = 0; i < RANDOM_ACTIONS; i++) begin
			a = random_action();
			if (i == 60)
				a.hold_rsp = 1'b1;
			if (i == 150)
				a.drain_first = 1'b1;
			action_queue.push_back(a);
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		do
			@(negedge clk);
		while (action_queue.size() != 0 || req_ch.valid === 1'b1 ||
			events_received != events_predicted);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (sched_events.size() != 0) begin
			$error("%0d expected transactions never arrived", sched_events.size());
			error_count++;
		end
		if (error_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#(CLK_PERIOD * RUN_LIMIT_CYCLES);
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/ptds_pkg.sv
rtl/ptds_req_if.sv
rtl/ptds_rsp_if.sv
rtl/ptds_slot_mem.sv
rtl/ptds_out_stage.sv
rtl/periodic_task_deadline_scheduler.sv
tb/tb_periodic_task_deadline_scheduler.sv
